/* hdl/clr_pkg.sv */
// Shared constants, types and register map of the clipped line rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package clr_pkg;

	// Coordinate width of target and pixel positions (two's complement).
	localparam int COORD_BITS = 12;

	// Derived widths of the line setup and the walking error term.
	localparam int DIFF_BITS  = COORD_BITS + 1;   // signed coordinate difference
	localparam int TWICE_BITS = COORD_BITS + 1;   // unsigned twice the absolute difference
	localparam int ERR_BITS   = COORD_BITS + 3;   // signed error term

	// Fixed widths of the configuration registers and result fields.
	localparam int COLOR_BITS  = 32;
	localparam int DIM_BITS    = 11;
	localparam int STRIDE_BITS = 13;
	localparam int OFFSET_BITS = 23;

	// APB port widths.
	localparam int PDATA_BITS = 32;
	localparam int PADDR_BITS = 4;

	// Register reset values.
	localparam logic [COLOR_BITS-1:0]  DRAW_COLOR_RST  = '0;
	localparam logic [DIM_BITS-1:0]    SCREEN_W_RST    = DIM_BITS'(640);
	localparam logic [DIM_BITS-1:0]    SCREEN_H_RST    = DIM_BITS'(480);
	localparam logic [STRIDE_BITS-1:0] ROW_STRIDE_RST  = STRIDE_BITS'(640);

	// Register indexes (byte address is four times the index).
	typedef enum logic [1:0] {
		REG_DRAW_COLOR    = 2'd0,
		REG_SCREEN_WIDTH  = 2'd1,
		REG_SCREEN_HEIGHT = 2'd2,
		REG_ROW_STRIDE    = 2'd3
	} reg_idx_t;

	// Command codes carried in the mode field of an input item.
	typedef enum logic [1:0] {
		MODE_MOVE  = 2'd0,
		MODE_LINE  = 2'd1,
		MODE_PIXEL = 2'd2
	} mode_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;

endpackage

`default_nettype wire

/* hdl/clipped_line_rasterizer.sv */
// Top level of the clipped line rasterizer: command intake, Bresenham walker and pixel output.
`timescale 1ns / 1ps
`default_nettype none

// The rasterizer draws lines with a pen. A move item places the pen, a line item
// loads a Bresenham walk from the pen to the target and moves the pen there, and
// each next-pixel item pulls one pixel of that walk: its coordinates, the draw
// color, the framebuffer word offset y * stride + x, a visible flag (clear, with
// a zero offset, when the pixel is off-screen) and a last flag on the endpoint.
// A next-pixel item while no line is active yields nothing, and a line item drops
// any walk in progress. The block takes one item per clock: the item is captured
// in an input register, and then one pass of logic (the 11 x 13 offset multiply
// plus add, and the error-term add and compare) updates the walker and fills the
// result register. The input side stalls only while that result register holds
// a pixel the sink has not taken. Configuration goes through an APB-style port
// with registers at byte addresses 0 (draw color), 4 (screen width), 8 (screen
// height) and 12 (row stride in words); it is meant to be written while the
// block is idle.
module clipped_line_rasterizer (
	input  wire                                   clk,
	input  wire                                   arst_n,

	// Command channel.
	input  wire                                   cmd_valid,
	output logic                                  cmd_ready,
	input  wire  [1:0]                            mode,
	input  wire  signed [clr_pkg::COORD_BITS-1:0] target_x,
	input  wire  signed [clr_pkg::COORD_BITS-1:0] target_y,

	// Pixel channel.
	output logic                                  pix_valid,
	input  wire                                   pix_ready,
	output logic signed [clr_pkg::COORD_BITS-1:0] pixel_x,
	output logic signed [clr_pkg::COORD_BITS-1:0] pixel_y,
	output logic [clr_pkg::COLOR_BITS-1:0]        pixel_color,
	output logic [clr_pkg::OFFSET_BITS-1:0]       word_offset,
	output logic                                  visible,
	output logic                                  last,

	// Configuration port.
	input  wire                                   psel,
	input  wire                                   penable,
	input  wire                                   pwrite,
	input  wire  [clr_pkg::PADDR_BITS-1:0]        paddr,
	input  wire  [clr_pkg::PDATA_BITS-1:0]        pwdata,
	output logic [clr_pkg::PDATA_BITS-1:0]        prdata,
	output logic                                  pready
);

	localparam int CB = clr_pkg::COORD_BITS;
	// Wide enough for y * stride + x at every coordinate width, and for the offset.
	localparam int OFF_CALC_BITS = CB + 15;

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	logic [clr_pkg::COLOR_BITS-1:0]  draw_color_q;
	logic [clr_pkg::DIM_BITS-1:0]    screen_width_q;
	logic [clr_pkg::DIM_BITS-1:0]    screen_height_q;
	logic [clr_pkg::STRIDE_BITS-1:0] row_stride_q;
	logic                            cfg_write;
	clr_pkg::reg_idx_t               cfg_idx;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign cfg_idx   = clr_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_color_q    <= clr_pkg::DRAW_COLOR_RST;
			screen_width_q  <= clr_pkg::SCREEN_W_RST;
			screen_height_q <= clr_pkg::SCREEN_H_RST;
			row_stride_q    <= clr_pkg::ROW_STRIDE_RST;
		end else if (cfg_write) begin
			case (cfg_idx)
				clr_pkg::REG_DRAW_COLOR:    draw_color_q    <= pwdata;
				clr_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= pwdata[clr_pkg::DIM_BITS-1:0];
				clr_pkg::REG_SCREEN_HEIGHT: screen_height_q <= pwdata[clr_pkg::DIM_BITS-1:0];
				clr_pkg::REG_ROW_STRIDE:    row_stride_q    <= pwdata[clr_pkg::STRIDE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Reads return the register zero-extended to the data width.
	always_comb begin
		case (cfg_idx)
			clr_pkg::REG_DRAW_COLOR:    prdata = draw_color_q;
			clr_pkg::REG_SCREEN_WIDTH:  prdata = clr_pkg::PDATA_BITS'(screen_width_q);
			clr_pkg::REG_SCREEN_HEIGHT: prdata = clr_pkg::PDATA_BITS'(screen_height_q);
			clr_pkg::REG_ROW_STRIDE:    prdata = clr_pkg::PDATA_BITS'(row_stride_q);
			default:                    prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------
	// Input register
	// ---------------------------------------------------------------------
	// An item sits in the input register until the processing pass can take it.
	// The pass goes ahead whenever the result register is empty or is being
	// emptied in this cycle, so with a willing sink an item flows every clock.
	logic                valid_s1;
	logic [1:0]          mode_s1;
	clr_pkg::coord_t     tx_s1;
	clr_pkg::coord_t     ty_s1;
	logic                pass_go;

	assign pass_go   = !pix_valid || pix_ready;
	assign cmd_ready = !valid_s1 || pass_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			mode_s1 <= mode;
			tx_s1   <= target_x;
			ty_s1   <= target_y;
		end
	end

	// ---------------------------------------------------------------------
	// Pen and walker state
	// ---------------------------------------------------------------------
	clr_pkg::coord_t                      pen_x_q, pen_y_q;
	clr_pkg::coord_t                      walk_x_q, walk_y_q;
	clr_pkg::coord_t                      end_x_q, end_y_q;
	logic [clr_pkg::TWICE_BITS-1:0]       twice_dx_q, twice_dy_q;
	logic signed [clr_pkg::ERR_BITS-1:0]  error_q;
	logic                                 step_x_neg_q, step_y_neg_q;
	logic                                 x_major_q;
	logic                                 line_active_q;

	logic do_move, do_line, do_pixel;

	assign do_move  = valid_s1 && pass_go && (mode_s1 == clr_pkg::MODE_MOVE);
	assign do_line  = valid_s1 && pass_go && (mode_s1 == clr_pkg::MODE_LINE);
	assign do_pixel = valid_s1 && pass_go && (mode_s1 == clr_pkg::MODE_PIXEL) && line_active_q;

	// Line setup: signed differences from the pen, their doubled magnitudes,
	// the major axis and the first error value 2*minor - major.
	logic signed [clr_pkg::DIFF_BITS-1:0]  dx, dy;
	logic [clr_pkg::DIFF_BITS-1:0]         abs_dx, abs_dy;
	logic [clr_pkg::TWICE_BITS-1:0]        ld_twice_dx, ld_twice_dy;
	logic                                  ld_x_major;
	logic signed [clr_pkg::ERR_BITS-1:0]   ld_error;

	always_comb begin
		dx          = clr_pkg::DIFF_BITS'(tx_s1) - clr_pkg::DIFF_BITS'(pen_x_q);
		dy          = clr_pkg::DIFF_BITS'(ty_s1) - clr_pkg::DIFF_BITS'(pen_y_q);
		abs_dx      = dx[clr_pkg::DIFF_BITS-1] ? -dx : dx;
		abs_dy      = dy[clr_pkg::DIFF_BITS-1] ? -dy : dy;
		// The magnitude fits one bit less than the difference, so the doubling
		// keeps every bit.
		ld_twice_dx = {abs_dx[clr_pkg::DIFF_BITS-2:0], 1'b0};
		ld_twice_dy = {abs_dy[clr_pkg::DIFF_BITS-2:0], 1'b0};
		ld_x_major  = ld_twice_dx > ld_twice_dy;
		if (ld_x_major) begin
			ld_error = clr_pkg::ERR_BITS'(ld_twice_dy) - clr_pkg::ERR_BITS'(abs_dx);
		end else begin
			ld_error = clr_pkg::ERR_BITS'(ld_twice_dx) - clr_pkg::ERR_BITS'(abs_dy);
		end
	end

	// One Bresenham step. On a tie the minor axis steps only when the major
	// axis walks in the positive direction.
	logic                                 major_neg;
	logic                                 minor_step;
	logic [clr_pkg::TWICE_BITS-1:0]       twice_major, twice_minor;
	logic signed [clr_pkg::ERR_BITS-1:0]  nx_error;
	clr_pkg::coord_t                      step_x, step_y;
	clr_pkg::coord_t                      nx_walk_x, nx_walk_y;
	logic                                 at_end;

	always_comb begin
		major_neg   = x_major_q ? step_x_neg_q : step_y_neg_q;
		twice_major = x_major_q ? twice_dx_q : twice_dy_q;
		twice_minor = x_major_q ? twice_dy_q : twice_dx_q;
		minor_step  = (error_q > 0) || ((error_q == 0) && !major_neg);
		nx_error    = error_q + clr_pkg::ERR_BITS'(twice_minor)
		              - (minor_step ? clr_pkg::ERR_BITS'(twice_major) : '0);
		step_x      = step_x_neg_q ? '1 : CB'(1);
		step_y      = step_y_neg_q ? '1 : CB'(1);
		nx_walk_x   = walk_x_q;
		nx_walk_y   = walk_y_q;
		if (x_major_q || minor_step) begin
			nx_walk_x = walk_x_q + step_x;
		end
		if (!x_major_q || minor_step) begin
			nx_walk_y = walk_y_q + step_y;
		end
		at_end = x_major_q ? (walk_x_q == end_x_q) : (walk_y_q == end_y_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q       <= '0;
			pen_y_q       <= '0;
			walk_x_q      <= '0;
			walk_y_q      <= '0;
			end_x_q       <= '0;
			end_y_q       <= '0;
			twice_dx_q    <= '0;
			twice_dy_q    <= '0;
			error_q       <= '0;
			step_x_neg_q  <= 1'b0;
			step_y_neg_q  <= 1'b0;
			x_major_q     <= 1'b0;
			line_active_q <= 1'b0;
		end else begin
			if (do_move) begin
				pen_x_q <= tx_s1;
				pen_y_q <= ty_s1;
			end
			if (do_line) begin
				pen_x_q       <= tx_s1;
				pen_y_q       <= ty_s1;
				walk_x_q      <= pen_x_q;
				walk_y_q      <= pen_y_q;
				end_x_q       <= tx_s1;
				end_y_q       <= ty_s1;
				twice_dx_q    <= ld_twice_dx;
				twice_dy_q    <= ld_twice_dy;
				error_q       <= ld_error;
				step_x_neg_q  <= dx[clr_pkg::DIFF_BITS-1];
				step_y_neg_q  <= dy[clr_pkg::DIFF_BITS-1];
				x_major_q     <= ld_x_major;
				line_active_q <= 1'b1;
			end
			if (do_pixel) begin
				if (at_end) begin
					line_active_q <= 1'b0;
				end else begin
					walk_x_q <= nx_walk_x;
					walk_y_q <= nx_walk_y;
					error_q  <= nx_error;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Clipping and framebuffer offset of the current pixel
	// ---------------------------------------------------------------------
	logic                         in_x, in_y, pix_visible;
	logic [OFF_CALC_BITS-1:0]     off_calc;
	logic [clr_pkg::OFFSET_BITS-1:0] pix_offset;

	always_comb begin
		// Negative coordinates are off-screen; otherwise compare at a common width.
		in_x = !walk_x_q[CB-1] &&
		       (OFF_CALC_BITS'(walk_x_q[CB-2:0]) < OFF_CALC_BITS'(screen_width_q));
		in_y = !walk_y_q[CB-1] &&
		       (OFF_CALC_BITS'(walk_y_q[CB-2:0]) < OFF_CALC_BITS'(screen_height_q));
		pix_visible = in_x && in_y;
		off_calc    = OFF_CALC_BITS'(walk_y_q[CB-2:0]) * OFF_CALC_BITS'(row_stride_q)
		              + OFF_CALC_BITS'(walk_x_q[CB-2:0]);
		pix_offset  = pix_visible ? off_calc[clr_pkg::OFFSET_BITS-1:0] : '0;
	end

	// ---------------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
		end else if (pass_go) begin
			pix_valid <= do_pixel;
		end
	end

	always_ff @(posedge clk) begin
		if (do_pixel) begin
			pixel_x     <= walk_x_q;
			pixel_y     <= walk_y_q;
			pixel_color <= draw_color_q;
			word_offset <= pix_offset;
			visible     <= pix_visible;
			last        <= at_end;
		end
	end

endmodule

`default_nettype wire

/* hdl/clr_checker.sv */
// Port-level checks of the clipped line rasterizer and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module clr_checker (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   pix_valid,
	input  wire                                   pix_ready,
	input  wire  signed [clr_pkg::COORD_BITS-1:0] pixel_x,
	input  wire  signed [clr_pkg::COORD_BITS-1:0] pixel_y,
	input  wire  [clr_pkg::COLOR_BITS-1:0]        pixel_color,
	input  wire  [clr_pkg::OFFSET_BITS-1:0]       word_offset,
	input  wire                                   visible,
	input  wire                                   last
);

	// A pixel item the sink has not taken stays put with its payload.
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(pixel_x) && $stable(pixel_y)
		&& $stable(pixel_color) && $stable(word_offset) && $stable(visible) && $stable(last))
		else $error("pixel item changed while stalled");

	// A clipped pixel carries no framebuffer offset.
	a_clip_offset: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !visible |-> word_offset == '0)
		else $error("clipped pixel with nonzero offset");

	// A visible pixel never has a negative coordinate.
	a_vis_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && visible |-> !pixel_x[clr_pkg::COORD_BITS-1] &&
		!pixel_y[clr_pkg::COORD_BITS-1])
		else $error("visible pixel at negative coordinate");

endmodule

bind clipped_line_rasterizer clr_checker u_clr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pix_valid   (pix_valid),
	.pix_ready   (pix_ready),
	.pixel_x     (pixel_x),
	.pixel_y     (pixel_y),
	.pixel_color (pixel_color),
	.word_offset (word_offset),
	.visible     (visible),
	.last        (last)
);

`default_nettype wire

/* tb/sv/clipped_line_rasterizer_tb.sv */
// Self-checking testbench for the clipped line rasterizer: directed and random pen strokes.
`timescale 1ns / 1ps

// The bench drives command items through the valid/ready command channel and
// pulls pixels from the pixel channel. Both sides insert random gaps. A predictor
// in this module tracks the pen, the Bresenham walker and the four screen
// registers, and works out the pixel that each accepted next-pixel item must give.
// A checker compares every accepted pixel with the oldest pending prediction.
// Registers are only reprogrammed once every predicted pixel has arrived and the
// pipeline has had time to finish any command that gives no pixel.
module clipped_line_rasterizer_tb;

	localparam int CLK_HALF = 6;
	localparam int RESET_CYCLES = 11;
	// Wait after the last pixel, so that commands that give no pixel clear the block's registers.
	localparam int SETTLE_CYCLES = 4;
	// Cycles in a row with no transfer on any port before the run is abandoned.
	// The longest legal pause is a long gap on one side plus a long stall on the other.
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 160;
	// The mode field can carry a fourth code that the block must ignore.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct {
		clr_pkg::coord_t                 x;
		clr_pkg::coord_t                 y;
		logic [clr_pkg::COLOR_BITS-1:0]  color;
		logic [clr_pkg::OFFSET_BITS-1:0] offset;
		logic                            vis;
		logic                            fin;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic cmd_valid = 1'b0;
	logic cmd_ready;
	logic [1:0] mode = 2'd0;
	clr_pkg::coord_t target_x = '0;
	clr_pkg::coord_t target_y = '0;

	logic pix_valid;
	logic pix_ready = 1'b0;
	clr_pkg::coord_t pixel_x;
	clr_pkg::coord_t pixel_y;
	logic [clr_pkg::COLOR_BITS-1:0] pixel_color;
	logic [clr_pkg::OFFSET_BITS-1:0] word_offset;
	logic visible;
	logic last;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [clr_pkg::PADDR_BITS-1:0] paddr = '0;
	logic [clr_pkg::PDATA_BITS-1:0] pwdata = '0;
	logic [clr_pkg::PDATA_BITS-1:0] prdata;
	logic pready;

	// Predictor copy of the screen registers, starting from their reset values.
	logic [clr_pkg::COLOR_BITS-1:0]  color_reg  = clr_pkg::DRAW_COLOR_RST;
	logic [clr_pkg::DIM_BITS-1:0]    width_reg  = clr_pkg::SCREEN_W_RST;
	logic [clr_pkg::DIM_BITS-1:0]    height_reg = clr_pkg::SCREEN_H_RST;
	logic [clr_pkg::STRIDE_BITS-1:0] stride_reg = clr_pkg::ROW_STRIDE_RST;

	// Predictor copy of the pen and of the line walker.
	clr_pkg::coord_t pos_x = '0;
	clr_pkg::coord_t pos_y = '0;
	clr_pkg::coord_t cur_x = '0;
	clr_pkg::coord_t cur_y = '0;
	clr_pkg::coord_t goal_x = '0;
	clr_pkg::coord_t goal_y = '0;
	logic [clr_pkg::TWICE_BITS-1:0] span2_x = '0;
	logic [clr_pkg::TWICE_BITS-1:0] span2_y = '0;
	logic signed [clr_pkg::ERR_BITS-1:0] err_acc = '0;
	logic neg_x = 1'b0;
	logic neg_y = 1'b0;
	logic along_x = 1'b0;
	logic busy_line = 1'b0;

	pixel_t pending_pixels[$];
	int mismatches = 0;
	int pixels_seen = 0;
	int useful_items = 0;
	int quiet_cycles = 0;
	// While set, neither side inserts gaps, so items stream back to back.
	bit steady = 1'b0;

	clipped_line_rasterizer uut (.*);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Gap length for either side: mostly none or short, now and then long.
	function automatic int idle_len();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic clr_pkg::coord_t wide_coord();
		return clr_pkg::coord_t'($urandom_range(0, 4095));
	endfunction

	// A coordinate within spread of center, held inside the coordinate range.
	function automatic clr_pkg::coord_t near_coord(clr_pkg::coord_t center, int spread);
		int v;
		v = int'($urandom_range(0, 2 * spread)) - spread + int'(center);
		if (v < -2048)
			v = -2048;
		if (v > 2047)
			v = 2047;
		return clr_pkg::coord_t'(v);
	endfunction

	// Apply one accepted command to the predicted state. A next-pixel command on an
	// active line queues the pixel it must produce. Returns 0 for commands that the
	// block ignores: the unused code and a next-pixel command with no line active.
	function automatic bit raster_step(logic [1:0] cmd, clr_pkg::coord_t tx,
		clr_pkg::coord_t ty);
		int dx;
		int dy;
		int off;
		pixel_t px;
		case (cmd)
			clr_pkg::MODE_MOVE: begin
				pos_x = tx;
				pos_y = ty;
				return 1'b1;
			end
			clr_pkg::MODE_LINE: begin
				dx = int'(tx) - int'(pos_x);
				dy = int'(ty) - int'(pos_y);
				span2_x = clr_pkg::TWICE_BITS'(2 * (dx < 0 ? -dx : dx));
				span2_y = clr_pkg::TWICE_BITS'(2 * (dy < 0 ? -dy : dy));
				neg_x = dx < 0;
				neg_y = dy < 0;
				cur_x = pos_x;
				cur_y = pos_y;
				goal_x = tx;
				goal_y = ty;
				along_x = span2_x > span2_y;
				if (along_x)
					err_acc = clr_pkg::ERR_BITS'(int'(span2_y) - int'(span2_x >> 1));
				else
					err_acc = clr_pkg::ERR_BITS'(int'(span2_x) - int'(span2_y >> 1));
				busy_line = 1'b1;
				pos_x = tx;
				pos_y = ty;
				return 1'b1;
			end
			clr_pkg::MODE_PIXEL: begin
				if (!busy_line)
					return 1'b0;
				px.x = cur_x;
				px.y = cur_y;
				px.color = color_reg;
				px.vis = cur_x >= 0 && cur_y >= 0 &&
					int'(cur_x) < int'(width_reg) && int'(cur_y) < int'(height_reg);
				off = px.vis ? int'(cur_y) * int'(stride_reg) + int'(cur_x) : 0;
				px.offset = off[clr_pkg::OFFSET_BITS-1:0];
				px.fin = along_x ? cur_x == goal_x : cur_y == goal_y;
				pending_pixels.push_back(px);
				if (px.fin) begin
					busy_line = 1'b0;
				end else if (along_x) begin
					// A tie steps the minor axis only when x runs forward.
					if (err_acc > 0 || (err_acc == 0 && !neg_x)) begin
						cur_y = clr_pkg::coord_t'(int'(cur_y) + (neg_y ? -1 : 1));
						err_acc = clr_pkg::ERR_BITS'(int'(err_acc) - int'(span2_x));
					end
					cur_x = clr_pkg::coord_t'(int'(cur_x) + (neg_x ? -1 : 1));
					err_acc = clr_pkg::ERR_BITS'(int'(err_acc) + int'(span2_y));
				end else begin
					// Same rule with the axes swapped: ties favor y running forward.
					if (err_acc > 0 || (err_acc == 0 && !neg_y)) begin
						cur_x = clr_pkg::coord_t'(int'(cur_x) + (neg_x ? -1 : 1));
						err_acc = clr_pkg::ERR_BITS'(int'(err_acc) - int'(span2_y));
					end
					cur_y = clr_pkg::coord_t'(int'(cur_y) + (neg_y ? -1 : 1));
					err_acc = clr_pkg::ERR_BITS'(int'(err_acc) + int'(span2_x));
				end
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Offer one command item and wait until it is accepted. Valid stays high from
	// one item to the next unless a gap is wanted, so it is never lowered and
	// raised again in one time step.
	task automatic send_cmd(logic [1:0] cmd, clr_pkg::coord_t tx, clr_pkg::coord_t ty);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		mode <= cmd;
		target_x <= tx;
		target_y <= ty;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		if (raster_step(cmd, tx, ty))
			useful_items++;
	endtask

	// Stop offering items and wait until every predicted pixel has come out, then
	// give the pipeline time to finish commands that make no pixel.
	task automatic settle();
		cmd_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One APB write followed by a read of the same register. The write lands at
	// the edge that closes its access cycle, where the predictor copy is updated too.
	task automatic write_reg(clr_pkg::reg_idx_t idx, logic [clr_pkg::PDATA_BITS-1:0] value);
		logic [clr_pkg::PDATA_BITS-1:0] stored;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= clr_pkg::PADDR_BITS'(idx * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			clr_pkg::REG_DRAW_COLOR: begin
				color_reg = value;
				stored = color_reg;
			end
			clr_pkg::REG_SCREEN_WIDTH: begin
				width_reg = value[clr_pkg::DIM_BITS-1:0];
				stored = clr_pkg::PDATA_BITS'(width_reg);
			end
			clr_pkg::REG_SCREEN_HEIGHT: begin
				height_reg = value[clr_pkg::DIM_BITS-1:0];
				stored = clr_pkg::PDATA_BITS'(height_reg);
			end
			default: begin
				stride_reg = value[clr_pkg::STRIDE_BITS-1:0];
				stored = clr_pkg::PDATA_BITS'(stride_reg);
			end
		endcase
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== stored) begin
			$display("%0t: register %s readback expected %0h got %0h",
				$time, idx.name(), stored, prdata);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic setup_surface(logic [31:0] color, int w, int h, int stride);
		settle();
		write_reg(clr_pkg::REG_DRAW_COLOR, color);
		write_reg(clr_pkg::REG_SCREEN_WIDTH, w);
		write_reg(clr_pkg::REG_SCREEN_HEIGHT, h);
		write_reg(clr_pkg::REG_ROW_STRIDE, stride);
	endtask

	// Right after reset: a next-pixel item with no line gives nothing, the unused
	// code must leave the pen at the origin, and a line to the pen's own position
	// gives a single pixel marked last.
	task automatic test_idle_and_zero_length();
		send_cmd(clr_pkg::MODE_PIXEL, 12'sd0, 12'sd0);
		send_cmd(MODE_UNUSED, 12'sd2047, -12'sd2048);
		send_cmd(clr_pkg::MODE_LINE, 12'sd0, 12'sd0);
		send_cmd(clr_pkg::MODE_PIXEL, 12'sd0, 12'sd0);
	endtask

	// The longest possible diagonal, from the most negative corner. A move during
	// the line shifts the pen but the walk carries on where it was.
	task automatic test_extreme_targets();
		send_cmd(clr_pkg::MODE_MOVE, -12'sd2048, -12'sd2048);
		send_cmd(clr_pkg::MODE_LINE, 12'sd2047, 12'sd2047);
		send_cmd(clr_pkg::MODE_PIXEL, 12'sd0, 12'sd0);
		send_cmd(clr_pkg::MODE_MOVE, 12'sd5, 12'sd5);
		send_cmd(clr_pkg::MODE_PIXEL, -12'sd1, -12'sd1);
	endtask

	// A new line drops the long walk. Both lines hit an exact tie on the first
	// step: going right the tie steps y at once, going left it does not.
	task automatic test_tie_rule();
		send_cmd(clr_pkg::MODE_LINE, 12'sd7, 12'sd6);
		repeat (3) send_cmd(clr_pkg::MODE_PIXEL, 12'sd0, 12'sd0);
		send_cmd(clr_pkg::MODE_LINE, 12'sd5, 12'sd5);
		repeat (3) send_cmd(clr_pkg::MODE_PIXEL, 12'sd0, 12'sd0);
	endtask

	// Largest and smallest screens, then a zero width and a zero height, where
	// every pixel is clipped whatever the stride.
	task automatic test_register_extremes();
		setup_surface(32'hFFFF_FFFF, 2047, 2047, 4096);
		send_cmd(clr_pkg::MODE_MOVE, 12'sd2045, 12'sd2045);
		send_cmd(clr_pkg::MODE_LINE, 12'sd2047, 12'sd2047);
		repeat (3) send_cmd(clr_pkg::MODE_PIXEL, 12'sd0, 12'sd0);
		setup_surface(32'h0000_0000, 1, 1, 1);
		send_cmd(clr_pkg::MODE_MOVE, -12'sd1, -12'sd1);
		send_cmd(clr_pkg::MODE_LINE, 12'sd1, 12'sd1);
		repeat (3) send_cmd(clr_pkg::MODE_PIXEL, 12'sd0, 12'sd0);
		setup_surface(32'hA5A5_5A5A, 0, 480, 0);
		send_cmd(clr_pkg::MODE_LINE, 12'sd1, 12'sd1);
		send_cmd(clr_pkg::MODE_PIXEL, 12'sd0, 12'sd0);
		setup_surface(32'h5A5A_A5A5, 2047, 0, 640);
		send_cmd(clr_pkg::MODE_LINE, 12'sd1, 12'sd1);
		send_cmd(clr_pkg::MODE_PIXEL, 12'sd0, 12'sd0);
	endtask

	// Registers rewritten halfway along a line: the later pixels take the new
	// color, and with a zero stride the offset collapses to x.
	task automatic test_midline_config();
		setup_surface(32'h1234_5678, 640, 480, 640);
		send_cmd(clr_pkg::MODE_LINE, 12'sd4, 12'sd3);
		repeat (2) send_cmd(clr_pkg::MODE_PIXEL, 12'sd0, 12'sd0);
		settle();
		write_reg(clr_pkg::REG_DRAW_COLOR, 32'h8765_4321);
		write_reg(clr_pkg::REG_ROW_STRIDE, 0);
		repeat (2) send_cmd(clr_pkg::MODE_PIXEL, 12'sd0, 12'sd0);
	endtask

	// One random stroke: usually an optional move, a line and the requests that
	// walk it to the end, sometimes a few extra requests past the endpoint or a
	// line left unfinished. Now and then a stray item of noise instead.
	task automatic random_stroke();
		int r;
		int dx;
		int dy;
		int len;
		int pulls;
		clr_pkg::coord_t tx;
		clr_pkg::coord_t ty;
		r = $urandom_range(0, 99);
		if (r < 6) begin
			send_cmd(MODE_UNUSED, wide_coord(), wide_coord());
			return;
		end
		if (r < 10) begin
			send_cmd(clr_pkg::MODE_PIXEL, wide_coord(), wide_coord());
			return;
		end
		if (r < 25)
			send_cmd(clr_pkg::MODE_MOVE, wide_coord(), wide_coord());
		else if (r < 45)
			send_cmd(clr_pkg::MODE_MOVE, near_coord(12'sd20, 40), near_coord(12'sd20, 40));
		// Mostly short lines around the pen, sometimes one across the whole range.
		if ($urandom_range(0, 7) == 0) begin
			tx = wide_coord();
			ty = wide_coord();
		end else begin
			tx = near_coord(pos_x, 12);
			ty = near_coord(pos_y, 12);
		end
		dx = int'(tx) - int'(pos_x);
		dy = int'(ty) - int'(pos_y);
		dx = dx < 0 ? -dx : dx;
		dy = dy < 0 ? -dy : dy;
		len = (dx > dy ? dx : dy) + 1;
		send_cmd(clr_pkg::MODE_LINE, tx, ty);
		r = $urandom_range(0, 99);
		if (r < 70)
			pulls = len;
		else if (r < 85)
			pulls = len + $urandom_range(1, 2);
		else
			pulls = $urandom_range(0, len - 1);
		if (pulls > 48)
			pulls = $urandom_range(8, 48);
		for (int i = 0; i < pulls; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_cmd(clr_pkg::MODE_MOVE, wide_coord(), wide_coord());
			send_cmd(clr_pkg::MODE_PIXEL, wide_coord(), wide_coord());
		end
	endtask

	// Four random phases on different screens: the default screen, a tiny one
	// streamed with no gaps, the largest with the widest stride so offsets wrap,
	// and a random one.
	task automatic test_random_strokes();
		int goal;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: setup_surface($urandom(), 640, 480, 640);
				1: setup_surface($urandom(), 64, 48, 64);
				2: setup_surface($urandom(), 2047, 2047, 8191);
				default: setup_surface($urandom(), $urandom_range(1, 100),
					$urandom_range(1, 100), $urandom_range(1, 4096));
			endcase
			steady = phase == 1;
			goal = useful_items + PHASE_ITEMS;
			while (useful_items < goal)
				random_stroke();
		end
		steady = 1'b0;
	endtask

	// Pixel sink: ready is raised or dropped at random, with long stalls now and then.
	initial begin : pixel_sink
		int hold;
		wait (arst_n);
		forever begin
			@(posedge clk);
			hold = idle_len();
			if (hold == 0) begin
				pix_ready <= 1'b1;
			end else begin
				pix_ready <= 1'b0;
				repeat (hold) @(posedge clk);
				pix_ready <= 1'b1;
			end
		end
	end

	// Four-state compare, so an unknown output bit counts as a mismatch.
	task automatic check_field(string name, logic signed [63:0] want,
		logic signed [63:0] got);
		if (want !== got) begin
			$display("%0t: pixel %0d %s expected %0d got %0d",
				$time, pixels_seen, name, want, got);
			mismatches++;
		end
	endtask

	// Every accepted pixel is matched against the oldest prediction.
	always @(posedge clk) begin : pixel_checker
		pixel_t want;
		if (arst_n && pix_valid && pix_ready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected pixel (%0d, %0d) expected none",
					$time, pixel_x, pixel_y);
				mismatches++;
			end else begin
				want = pending_pixels.pop_front();
				check_field("pixel_x", want.x, pixel_x);
				check_field("pixel_y", want.y, pixel_y);
				check_field("pixel_color", want.color, pixel_color);
				check_field("word_offset", want.offset, word_offset);
				check_field("visible", want.vis, visible);
				check_field("last", want.fin, last);
			end
			pixels_seen++;
		end
	end

	// Watchdog: a hang shows up as a long run of cycles with no transfer anywhere.
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (pix_valid && pix_ready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : run
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_and_zero_length();
		test_extreme_targets();
		test_tie_rule();
		test_register_extremes();
		test_midline_config();
		test_random_strokes();
		settle();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
